>>> design/wbc_pkg.sv
package wbc_pkg;

  // cache geometry
  localparam int SETS        = 64;
  localparam int WAYS        = 2;
  localparam int BLOCK_BYTES = 32;
  localparam int ADDR_WIDTH  = 32;

  // fixed field widths on the ports
  localparam int ADDR_FIELD_W = 32;
  localparam int PENALTY_W    = 8;
  localparam int PID_W        = 4;
  localparam int CFG_INDEX_W  = 1;
  localparam int CFG_DATA_W   = 8;

  localparam int OFFSET_W = $clog2(BLOCK_BYTES);
  localparam int SET_W    = $clog2(SETS);
  localparam int TAG_W    = ADDR_WIDTH - OFFSET_W - SET_W;
  localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int ROW_W    = WAYS * TAG_W;

  localparam int LFSR_W = 16;
  localparam logic [LFSR_W-1:0]    LFSR_SEED     = 16'hACE1;
  localparam logic [PENALTY_W-1:0] PENALTY_RESET = 8'd10;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_MISS_PENALTY = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PROCESSOR_ID = 1'd1;

  // reciprocal for the victim modulo: q = (s * WAY_RECIP) >> 32 is floor or floor - 1
  localparam logic [32:0] WAY_RECIP = 33'((64'd1 << 32) / WAYS);
  localparam logic [20:0] WAYS_C    = 21'(WAYS);

  // one step right, taps 16, 14, 13, 11
  function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] s);
    logic fb;
    fb = s[0] ^ s[2] ^ s[3] ^ s[5];
    return {fb, s[LFSR_W-1:1]};
  endfunction

  function automatic logic [WAY_W-1:0] way_of(input logic [LFSR_W-1:0] s);
    logic [48:0] prod;
    logic [15:0] q;
    logic [20:0] r;
    prod = 49'(s) * 49'(WAY_RECIP);
    q    = prod[47:32];
    r    = 21'(s) - 21'(q) * WAYS_C;
    if (r >= WAYS_C) begin
      r = r - WAYS_C;
    end
    return r[WAY_W-1:0];
  endfunction

endpackage

>>> design/wbc_req_if.sv
interface wbc_req_if;
  logic                              valid;
  logic                              ready;
  logic                              mode;
  logic [wbc_pkg::ADDR_FIELD_W-1:0]  address;

  modport source (output valid, mode, address, input ready);
  modport sink   (input valid, mode, address, output ready);
endinterface

>>> design/wbc_rsp_if.sv
interface wbc_rsp_if;
  logic                              valid;
  logic                              ready;
  logic                              hit;
  logic [wbc_pkg::PENALTY_W-1:0]     wait_added;
  logic                              fetch_request;
  logic [wbc_pkg::ADDR_FIELD_W-1:0]  fetch_address;
  logic                              writeback_request;
  logic [wbc_pkg::ADDR_FIELD_W-1:0]  writeback_address;
  logic [wbc_pkg::PID_W-1:0]         requester;

  modport source (output valid, hit, wait_added, fetch_request, fetch_address,
                  writeback_request, writeback_address, requester, input ready);
  modport sink   (input valid, hit, wait_added, fetch_request, fetch_address,
                  writeback_request, writeback_address, requester, output ready);
endinterface

>>> design/writeback_cache_controller_core.sv
// Set-associative write-back cache controller (tags, valid and dirty state only).
// For each item the set's tag row is read from the tag RAM in the cycle after
// acceptance, then the ways are compared, the row is written back on a miss and
// the result is loaded into the output register. The next item is accepted in
// the cycle after that, so an item is never taken while the last is in flight,
// as the single tag RAM port pair is read and then written. A result
// waiting on the output register does not block acceptance; it only holds the
// compare cycle of the following item. Valid and dirty bits are flip-flops
// cleared by reset, so no clearing pass is needed and items are taken right
// after reset. Victims are chosen by a 16-bit LFSR that advances once per miss.
module writeback_cache_controller_core (
  input  logic                              clk,
  input  logic                              rst,
  wbc_req_if.sink                           req,
  wbc_rsp_if.source                         rsp,
  input  logic                              cfg_write,
  input  logic [wbc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [wbc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  typedef enum logic {IDLE, LOOKUP} state_t;

  state_t                            state;
  logic [wbc_pkg::PENALTY_W-1:0]     miss_penalty;
  logic [wbc_pkg::PID_W-1:0]         processor_id;
  logic [wbc_pkg::LFSR_W-1:0]        lfsr;
  logic [wbc_pkg::WAYS-1:0]          valid_bits [wbc_pkg::SETS];
  logic [wbc_pkg::WAYS-1:0]          dirty_bits [wbc_pkg::SETS];

  logic                              mode_r;
  logic [wbc_pkg::ADDR_WIDTH-1:0]    addr_r;
  logic [wbc_pkg::WAY_W-1:0]         victim;

  logic [wbc_pkg::SET_W-1:0]         set_r;
  logic [wbc_pkg::TAG_W-1:0]         tag_r;
  logic [wbc_pkg::ROW_W-1:0]         row_rdata;
  logic [wbc_pkg::ROW_W-1:0]         row_wdata;
  logic [wbc_pkg::WAYS-1:0]          row_valid;
  logic [wbc_pkg::WAYS-1:0]          row_dirty;
  logic [wbc_pkg::TAG_W-1:0]         victim_tag;
  logic                              hit_any;
  logic [wbc_pkg::WAY_W-1:0]         hit_way;
  logic                              wb;
  logic [wbc_pkg::ADDR_WIDTH-1:0]    wb_addr;
  logic                              accept;
  logic                              finish;
  logic                              ram_we;

  assign set_r     = addr_r[wbc_pkg::OFFSET_W +: wbc_pkg::SET_W];
  assign tag_r     = addr_r[wbc_pkg::ADDR_WIDTH-1 -: wbc_pkg::TAG_W];
  assign row_valid = valid_bits[set_r];
  assign row_dirty = dirty_bits[set_r];

  assign req.ready = (state == IDLE);
  assign accept    = req.valid && req.ready;
  assign finish    = (state == LOOKUP) && (!rsp.valid || rsp.ready);
  assign ram_we    = finish && !hit_any;

  // lowest matching way wins
  always_comb begin
    hit_any = 1'b0;
    hit_way = '0;
    for (int w = wbc_pkg::WAYS - 1; w >= 0; w--) begin
      if (row_valid[w] && row_rdata[w*wbc_pkg::TAG_W +: wbc_pkg::TAG_W] == tag_r) begin
        hit_any = 1'b1;
        hit_way = wbc_pkg::WAY_W'(w);
      end
    end
  end

  always_comb begin
    victim_tag = row_rdata[victim*wbc_pkg::TAG_W +: wbc_pkg::TAG_W];
    row_wdata  = row_rdata;
    row_wdata[victim*wbc_pkg::TAG_W +: wbc_pkg::TAG_W] = tag_r;
    wb         = !hit_any && row_valid[victim] && row_dirty[victim];
    wb_addr    = {victim_tag, set_r, {wbc_pkg::OFFSET_W{1'b0}}};
  end

  wbc_ram #(
    .WIDTH (wbc_pkg::ROW_W),
    .DEPTH (wbc_pkg::SETS)
  ) u_tag_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (set_r),
    .wdata (row_wdata),
    .re    (accept),
    .raddr (req.address[wbc_pkg::OFFSET_W +: wbc_pkg::SET_W]),
    .rdata (row_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      rsp.valid    <= 1'b0;
      miss_penalty <= wbc_pkg::PENALTY_RESET;
      processor_id <= '0;
      lfsr         <= wbc_pkg::LFSR_SEED;
      for (int s = 0; s < wbc_pkg::SETS; s++) begin
        valid_bits[s] <= '0;
        dirty_bits[s] <= '0;
      end
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          wbc_pkg::REG_MISS_PENALTY: miss_penalty <= cfg_data[wbc_pkg::PENALTY_W-1:0];
          wbc_pkg::REG_PROCESSOR_ID: processor_id <= cfg_data[wbc_pkg::PID_W-1:0];
        endcase
      end

      // a finishing item reloads the output register instead
      if (rsp.valid && rsp.ready && !finish) begin
        rsp.valid <= 1'b0;
      end

      unique case (state)
        IDLE: begin
          if (req.valid) begin
            mode_r <= req.mode;
            addr_r <= req.address[wbc_pkg::ADDR_WIDTH-1:0];
            // lfsr is stable until the compare cycle, so the victim is known early
            victim <= wbc_pkg::way_of(wbc_pkg::lfsr_step(lfsr));
            state  <= LOOKUP;
          end
        end
        LOOKUP: begin
          if (finish) begin
            if (hit_any) begin
              if (mode_r) begin
                dirty_bits[set_r][hit_way] <= 1'b1;
              end
            end else begin
              lfsr                      <= wbc_pkg::lfsr_step(lfsr);
              valid_bits[set_r][victim] <= 1'b1;
              dirty_bits[set_r][victim] <= mode_r;
            end
            rsp.valid             <= 1'b1;
            rsp.hit               <= hit_any;
            rsp.wait_added        <= hit_any ? '0 : miss_penalty;
            rsp.fetch_request     <= !hit_any;
            rsp.fetch_address     <= hit_any ? '0 : wbc_pkg::ADDR_FIELD_W'(addr_r);
            rsp.writeback_request <= wb;
            rsp.writeback_address <= wb ? wbc_pkg::ADDR_FIELD_W'(wb_addr) : '0;
            rsp.requester         <= processor_id;
            state                 <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_accept_to_lookup: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == LOOKUP)
    else $error("accepted item did not enter lookup");

  a_ram_write_on_miss: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == LOOKUP) && !hit_any && !accept)
    else $error("tag row written outside a miss");

  a_lfsr_nonzero: assert property (@(posedge clk) disable iff (rst)
    lfsr != '0)
    else $error("victim lfsr locked at zero");

  a_lfsr_moves_on_miss: assert property (@(posedge clk) disable iff (rst)
    finish && !hit_any |=> lfsr != $past(lfsr))
    else $error("lfsr did not advance on a miss");

  a_wb_implies_fetch: assert property (@(posedge clk) disable iff (rst)
    finish && wb |=> rsp.valid && rsp.fetch_request && rsp.writeback_request)
    else $error("writeback without fetch");
`endif

endmodule

>>> design/wbc_ram.sv
module wbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> dv/writeback_cache_controller_core_tb.sv
`timescale 1ns / 100ps

module writeback_cache_controller_core_tb;

  localparam bit ACC_READ  = 1'b0;
  localparam bit ACC_WRITE = 1'b1;

  localparam int N_DIRECTED      = 18;
  localparam int N_PHASES        = 4;
  localparam int ITEMS_PER_PHASE = 96;
  localparam int TAG_POOL        = 5;
  localparam int HOT_SETS        = 4;
  localparam int CYCLE_LIMIT     = 300000;

  typedef struct packed {
    logic                             hit;
    logic [wbc_pkg::PENALTY_W-1:0]    wait_added;
    logic                             fetch_request;
    logic [wbc_pkg::ADDR_FIELD_W-1:0] fetch_address;
    logic                             writeback_request;
    logic [wbc_pkg::ADDR_FIELD_W-1:0] writeback_address;
    logic [wbc_pkg::PID_W-1:0]        requester;
  } cache_result_t;

  // Tag/valid/dirty mirror of the cache plus the queue of outcomes still owed.
  class cache_scoreboard;
    logic [wbc_pkg::TAG_W-1:0]     line_tag   [wbc_pkg::SETS][wbc_pkg::WAYS];
    bit                            line_valid [wbc_pkg::SETS][wbc_pkg::WAYS];
    bit                            line_dirty [wbc_pkg::SETS][wbc_pkg::WAYS];
    logic [wbc_pkg::LFSR_W-1:0]    victim_lfsr;
    logic [wbc_pkg::PENALTY_W-1:0] penalty;
    logic [wbc_pkg::PID_W-1:0]     pid;
    cache_result_t                 outcome_q[$];
    int                            errors;

    function new();
      foreach (line_valid[s, w]) begin
        line_tag[s][w]   = '0;
        line_valid[s][w] = 1'b0;
        line_dirty[s][w] = 1'b0;
      end
      victim_lfsr = wbc_pkg::LFSR_SEED;
      penalty     = wbc_pkg::PENALTY_RESET;
      pid         = '0;
      errors      = 0;
    endfunction

    function void set_regs(logic [wbc_pkg::PENALTY_W-1:0] p, logic [wbc_pkg::PID_W-1:0] id);
      penalty = p;
      pid     = id;
    endfunction

    function void note_access(bit is_write, logic [wbc_pkg::ADDR_FIELD_W-1:0] address);
      logic [wbc_pkg::ADDR_WIDTH-1:0] a;
      logic [wbc_pkg::SET_W-1:0]      s;
      logic [wbc_pkg::TAG_W-1:0]      t;
      logic                           fb;
      int                             way;
      bit                             found;
      cache_result_t                  r;
      a     = address[wbc_pkg::ADDR_WIDTH-1:0];
      s     = a[wbc_pkg::OFFSET_W +: wbc_pkg::SET_W];
      t     = a[wbc_pkg::ADDR_WIDTH-1 -: wbc_pkg::TAG_W];
      found = 1'b0;
      way   = 0;
      // scan downward so the lowest matching way wins
      for (int w = wbc_pkg::WAYS - 1; w >= 0; w--) begin
        if (line_valid[s][w] && line_tag[s][w] == t) begin
          found = 1'b1;
          way   = w;
        end
      end
      r           = '0;
      r.hit       = found;
      r.requester = pid;
      if (found) begin
        if (is_write) begin
          line_dirty[s][way] = 1'b1;
        end
      end else begin
        fb          = victim_lfsr[0] ^ victim_lfsr[2] ^ victim_lfsr[3] ^ victim_lfsr[5];
        victim_lfsr = {fb, victim_lfsr[wbc_pkg::LFSR_W-1:1]};
        way         = int'(victim_lfsr) % wbc_pkg::WAYS;
        r.wait_added    = penalty;
        r.fetch_request = 1'b1;
        r.fetch_address = wbc_pkg::ADDR_FIELD_W'(a);
        if (line_valid[s][way] && line_dirty[s][way]) begin
          r.writeback_request = 1'b1;
          r.writeback_address = wbc_pkg::ADDR_FIELD_W'({line_tag[s][way], s,
                                                        {wbc_pkg::OFFSET_W{1'b0}}});
        end
        line_tag[s][way]   = t;
        line_valid[s][way] = 1'b1;
        line_dirty[s][way] = is_write;
      end
      outcome_q.push_back(r);
    endfunction

    function void field_check(string name, logic [wbc_pkg::ADDR_FIELD_W-1:0] exp_v,
                              logic [wbc_pkg::ADDR_FIELD_W-1:0] got_v);
      if (got_v !== exp_v) begin
        errors++;
        $display("%0t ns: %s mismatch: expected %0h, got %0h", $time, name, exp_v, got_v);
      end
    endfunction

    function void check_result(cache_result_t got);
      cache_result_t exp_r;
      if (outcome_q.size() == 0) begin
        errors++;
        $display("%0t ns: result with no access pending: expected none, got %h", $time, got);
        return;
      end
      exp_r = outcome_q.pop_front();
      field_check("hit", wbc_pkg::ADDR_FIELD_W'(exp_r.hit),
                  wbc_pkg::ADDR_FIELD_W'(got.hit));
      field_check("wait_added", wbc_pkg::ADDR_FIELD_W'(exp_r.wait_added),
                  wbc_pkg::ADDR_FIELD_W'(got.wait_added));
      field_check("fetch_request", wbc_pkg::ADDR_FIELD_W'(exp_r.fetch_request),
                  wbc_pkg::ADDR_FIELD_W'(got.fetch_request));
      field_check("fetch_address", exp_r.fetch_address, got.fetch_address);
      field_check("writeback_request", wbc_pkg::ADDR_FIELD_W'(exp_r.writeback_request),
                  wbc_pkg::ADDR_FIELD_W'(got.writeback_request));
      field_check("writeback_address", exp_r.writeback_address, got.writeback_address);
      field_check("requester", wbc_pkg::ADDR_FIELD_W'(exp_r.requester),
                  wbc_pkg::ADDR_FIELD_W'(got.requester));
    endfunction
  endclass

  logic                            clk;
  logic                            rst;
  logic                            cfg_write;
  logic [wbc_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [wbc_pkg::CFG_DATA_W-1:0]  cfg_data;
  int unsigned                     cycles = 0;
  cache_scoreboard                 sb;

  wbc_req_if req_ch ();
  wbc_rsp_if rsp_ch ();

  writeback_cache_controller_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic int idle_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  function automatic logic [wbc_pkg::ADDR_FIELD_W-1:0] make_addr(
      logic [wbc_pkg::TAG_W-1:0] t, logic [wbc_pkg::SET_W-1:0] s,
      logic [wbc_pkg::OFFSET_W-1:0] o);
    return wbc_pkg::ADDR_FIELD_W'({t, s, o});
  endfunction

  // all tasks start and end just after a falling edge
  task automatic write_regs(logic [wbc_pkg::PENALTY_W-1:0] p, logic [wbc_pkg::PID_W-1:0] id);
    sb.set_regs(p, id);
    cfg_write <= 1'b1;
    cfg_index <= wbc_pkg::REG_MISS_PENALTY;
    cfg_data  <= wbc_pkg::CFG_DATA_W'(p);
    @(negedge clk);
    cfg_index <= wbc_pkg::REG_PROCESSOR_ID;
    cfg_data  <= wbc_pkg::CFG_DATA_W'(id);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic send_access(bit m, logic [wbc_pkg::ADDR_FIELD_W-1:0] a, int gap);
    repeat (gap) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.mode    <= m;
    req_ch.address <= a;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    while (sb.outcome_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // response side back-pressure
  initial begin
    int stall;
    int run;
    forever begin
      if ($urandom_range(7) == 0) begin
        stall = 0;
        run   = 40;
      end else begin
        stall = idle_gap();
        run   = $urandom_range(4, 1);
      end
      repeat (stall) begin
        @(negedge clk);
        rsp_ch.ready <= 1'b0;
      end
      repeat (run) begin
        @(negedge clk);
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // check results before noting new items accepted on the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        sb.check_result(cache_result_t'({rsp_ch.hit, rsp_ch.wait_added, rsp_ch.fetch_request,
                                         rsp_ch.fetch_address, rsp_ch.writeback_request,
                                         rsp_ch.writeback_address, rsp_ch.requester}));
      end
      if (req_ch.valid && req_ch.ready) begin
        sb.note_access(req_ch.mode, req_ch.address);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("writeback_cache_controller_core_tb NOT OK");
      $finish;
    end
  end

  initial begin
    logic [wbc_pkg::ADDR_FIELD_W-1:0] dir_addr [N_DIRECTED];
    bit                               dir_mode [N_DIRECTED];
    logic [wbc_pkg::TAG_W-1:0]        tag_pool [TAG_POOL];
    logic [wbc_pkg::ADDR_FIELD_W-1:0] a;
    logic [wbc_pkg::SET_W-1:0]        s;
    bit                               burst;

    sb             = new();
    rst            = 1'b1;
    req_ch.valid   = 1'b0;
    req_ch.mode    = ACC_READ;
    req_ch.address = '0;
    rsp_ch.ready   = 1'b0;
    cfg_write      = 1'b0;
    cfg_index      = wbc_pkg::REG_MISS_PENALTY;
    cfg_data       = '0;

    // set 0 churn forces dirty evictions; set 63 covers the all-ones tag
    dir_addr = '{32'h0000_0000, 32'h0000_001F, 32'h0000_0000, 32'h0000_0800,
                 32'h0000_1000, 32'h0000_1800, 32'h0000_2000, 32'h0000_2800,
                 32'hFFFF_FFFF, 32'hFFFF_FFE0, 32'hFFFF_F7E0, 32'hFFFF_EFE0,
                 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hAAAA_AAAA,
                 32'h5555_5555, 32'hAAAA_AAAA};
    dir_mode = '{ACC_READ,  ACC_READ,  ACC_WRITE, ACC_WRITE, ACC_READ,  ACC_READ,
                 ACC_WRITE, ACC_READ,  ACC_READ,  ACC_WRITE, ACC_READ,  ACC_WRITE,
                 ACC_READ,  ACC_WRITE, ACC_READ,  ACC_WRITE, ACC_WRITE, ACC_READ};

    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    write_regs('1, '1);
    for (int i = 0; i < N_DIRECTED; i++) begin
      send_access(dir_mode[i], dir_addr[i], idle_gap());
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      wait_idle();
      case (ph)
        0: write_regs('0, '0);
        2: write_regs(wbc_pkg::PENALTY_W'(128), wbc_pkg::PID_W'(10));
        default: write_regs(wbc_pkg::PENALTY_W'($urandom()), wbc_pkg::PID_W'($urandom()));
      endcase
      foreach (tag_pool[k]) tag_pool[k] = wbc_pkg::TAG_W'($urandom());
      burst = 1'b0;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (i % 32 == 0) burst = ($urandom_range(3) == 0);
        if ($urandom_range(99) < 12) begin
          a = $urandom();
        end else begin
          if ($urandom_range(9) < 7) s = wbc_pkg::SET_W'($urandom_range(HOT_SETS - 1));
          else s = wbc_pkg::SET_W'($urandom_range(wbc_pkg::SETS - 1));
          a = make_addr(tag_pool[$urandom_range(TAG_POOL - 1)], s,
                        wbc_pkg::OFFSET_W'($urandom_range(wbc_pkg::BLOCK_BYTES - 1)));
        end
        send_access($urandom_range(1), a, burst ? 0 : idle_gap());
      end
    end

    wait_idle();
    repeat (20) @(negedge clk);
    if (sb.errors == 0 && sb.outcome_q.size() == 0) begin
      $display("writeback_cache_controller_core_tb OK");
    end else begin
      $display("writeback_cache_controller_core_tb NOT OK");
    end
    $finish;
  end

endmodule

>>> sim.f
design/wbc_pkg.sv
design/wbc_req_if.sv
design/wbc_rsp_if.sv
design/wbc_ram.sv
design/writeback_cache_controller_core.sv
dv/writeback_cache_controller_core_tb.sv
